>>> design/edge_period_frequency_meter_top_defines.svh
// assertion macros for the edge period frequency meter
// used by the top level; expects clk and rst_n in the including scope
`ifndef EDGE_PERIOD_FREQUENCY_METER_TOP_DEFINES_SVH
`define EDGE_PERIOD_FREQUENCY_METER_TOP_DEFINES_SVH

// same-cycle implication
`define EPFM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EPFM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/epfm_pkg.sv
// shared types and constants of the edge period frequency meter
// no dependencies
package epfm_pkg;

    localparam int TIME_W   = 63;
    localparam int FREQ_W   = 50;
    localparam int AVG_W    = 57;
    localparam int SEEN_W   = 32;
    localparam int DVSR_W   = 64;

    localparam int COUNT_BITS_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 8;

    localparam logic [FREQ_W-1:0] FS_PER_S = 50'd1000000000000000;
    localparam logic [AVG_W-1:0]  AVG_MAX  = {AVG_W{1'b1}};

    typedef enum logic [1:0] {
        KIND_PERIOD  = 2'd0,
        KIND_AVERAGE = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [TIME_W-1:0] edge_time;
        logic              has_edge;
        logic              end_of_capture;
    } in_item_t;

    typedef struct packed {
        kind_t             kind;
        logic [TIME_W-1:0] period_start;
        logic [TIME_W-1:0] period_length;
        logic [FREQ_W-1:0] freq_hz;
        logic [AVG_W-1:0]  avg_freq_q8;
        logic [SEEN_W-1:0] edges_seen;
    } out_item_t;

    // divider request and status
    typedef struct packed {
        logic start;
        logic short_num;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic over;
    } div_stat_t;

endpackage

>>> design/epfm_ifs.sv
// valid/ready channel interfaces for edge items and result items
// depends on epfm_pkg
interface epfm_in_if;
    logic               valid;
    logic               ready;
    epfm_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface epfm_out_if;
    logic                valid;
    logic                ready;
    epfm_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/epfm_div.sv
// serial restoring divider, one quotient bit per cycle, quotient saturation flag
// depends on epfm_pkg
module epfm_div #(
    parameter int NUM_W = 91
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  epfm_pkg::div_req_t            req,
    input  logic [NUM_W-1:0]              numerator,
    input  logic [epfm_pkg::DVSR_W-1:0]   divisor,
    output epfm_pkg::div_stat_t           stat,
    output logic [epfm_pkg::AVG_W-1:0]    quotient
);
    import epfm_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  num_reg,  num_next;
    logic [DVSR_W-1:0] rem_reg,  rem_next;
    logic [AVG_W-1:0]  q_reg,    q_next;
    logic              over_reg, over_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DVSR_W:0] trial;
    logic [DVSR_W:0] diff;
    logic            ge;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        over_next = over_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            num_next  = req.short_num ? (numerator << (NUM_W - DVSR_W)) : numerator;
            rem_next  = '0;
            q_next    = '0;
            over_next = 1'b0;
            cnt_next  = req.short_num ? CNT_W'(DVSR_W) : CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next  = num_reg << 1;
            rem_next  = ge ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
            q_next    = {q_reg[AVG_W-2:0], ge};
            over_next = over_reg | q_reg[AVG_W-1];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        over_reg <= over_next;
    end

    assign stat.done = done_reg;
    assign stat.over = over_reg;
    assign quotient  = q_reg;

endmodule

>>> design/edge_period_frequency_meter_top.sv
// edge period frequency meter: capture state, sequencer and output register
// depends on epfm_pkg, epfm_ifs, epfm_div and the assertion macro header
//
// edges carries one transaction per edge timestamp (femtoseconds) with a
// has_edge flag and an end_of_capture flag. results carries at most one
// result transaction per input transaction: a period (start, length, rounded
// frequency), a capture average in Q.FRACTION_BITS Hz, or a too-few-edges error.
// Items that emit nothing are taken without leaving the idle state. A period
// result runs one serial 64-step division, unless its length is zero.
// A capture average first runs a shift-add multiply of (edges-1) by 1e15, one
// step per significant bit of the count (at most COUNT_BITS), then one serial
// division of NUM_W steps (COUNT_BITS+FRACTION_BITS+51, at least 64; 91 at the
// defaults). Both kinds share the one subtractor of the divider.
// edges.ready is high only while no item is in work. A finished result sits
// in the output register; a stalled receiver holds the next finished result
// in the sequencer and thereby holds off edges.
// Reset clears the capture state and the channels; there is no clearing pass.
`include "edge_period_frequency_meter_top_defines.svh"

module edge_period_frequency_meter_top #(
    parameter int COUNT_BITS    = epfm_pkg::COUNT_BITS_DEF,
    parameter int FRACTION_BITS = epfm_pkg::FRACTION_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    epfm_in_if.sink            edges,
    epfm_out_if.source         results
);
    import epfm_pkg::*;

    localparam int NUM_W = (COUNT_BITS + FRACTION_BITS + 51 > DVSR_W)
                         ? COUNT_BITS + FRACTION_BITS + 51 : DVSR_W;
    localparam int EXT_W = (COUNT_BITS > SEEN_W) ? COUNT_BITS : SEEN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV_GO,
        S_DIV,
        S_DONE
    } state_t;

    state_t                state_reg,  state_next;
    logic [COUNT_BITS-1:0] count_reg,  count_next;
    logic [TIME_W-1:0]     first_reg,  first_next;
    logic [TIME_W-1:0]     anchor_reg, anchor_next;
    logic [TIME_W-1:0]     last_reg,   last_next;
    logic [COUNT_BITS-1:0] mcnt_reg,   mcnt_next;
    logic [NUM_W-1:0]      addend_reg, addend_next;
    logic [NUM_W-1:0]      acc_reg,    acc_next;
    logic [DVSR_W-1:0]     dvsr_reg,   dvsr_next;
    out_item_t             res_reg,    res_next;
    logic                  ovalid_reg, ovalid_next;
    out_item_t             odata_reg,  odata_next;

    div_req_t          div_req;
    div_stat_t         div_stat;
    logic [AVG_W-1:0]  div_q;

    in_item_t              item;
    logic                  counting;
    logic [COUNT_BITS-1:0] cnt_upd;
    logic [TIME_W-1:0]     first_upd;
    logic [TIME_W-1:0]     last_upd;
    logic [TIME_W-1:0]     len;
    logic [TIME_W-1:0]     iv;
    logic                  period_hit;
    logic [EXT_W-1:0]      count_ext;
    logic [SEEN_W-1:0]     seen;

    assign item       = edges.data;
    assign counting   = item.has_edge && (count_reg != '1);
    assign cnt_upd    = counting ? count_reg + 1'b1 : count_reg;
    assign first_upd  = (counting && count_reg == '0) ? item.edge_time : first_reg;
    assign last_upd   = item.has_edge ? item.edge_time : last_reg;
    assign len        = item.edge_time - anchor_reg;
    assign iv         = last_upd - first_upd;
    assign period_hit = counting && !count_reg[0] && (count_reg[COUNT_BITS-1:1] != '0)
                        && !item.end_of_capture;
    assign count_ext  = EXT_W'(cnt_upd);
    assign seen       = (count_ext > EXT_W'({SEEN_W{1'b1}})) ? '1 : count_ext[SEEN_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        first_next  = first_reg;
        anchor_next = anchor_reg;
        last_next   = last_reg;
        mcnt_next   = mcnt_reg;
        addend_next = addend_reg;
        acc_next    = acc_reg;
        dvsr_next   = dvsr_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg && !results.ready;
        odata_next  = odata_reg;
        div_req     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (edges.valid)
                begin
                    count_next = cnt_upd;
                    first_next = first_upd;
                    last_next  = last_upd;
                    if (counting && !count_reg[0])
                        anchor_next = item.edge_time;
                    res_next = '0;
                    if (period_hit)
                    begin
                        res_next.kind          = KIND_PERIOD;
                        res_next.period_start  = anchor_reg;
                        res_next.period_length = len;
                        if (len == '0)
                        begin
                            res_next.freq_hz = FS_PER_S;
                            state_next       = S_DONE;
                        end
                        else
                        begin
                            acc_next   = NUM_W'(DVSR_W'(FS_PER_S) + DVSR_W'(len >> 1));
                            dvsr_next  = DVSR_W'(len);
                            state_next = S_DIV_GO;
                        end
                    end
                    if (item.end_of_capture)
                    begin
                        count_next          = '0;
                        first_next          = '0;
                        anchor_next         = '0;
                        last_next           = '0;
                        res_next.edges_seen = seen;
                        if (cnt_upd[COUNT_BITS-1:1] == '0)
                        begin
                            res_next.kind = KIND_ERROR;
                            state_next    = S_DONE;
                        end
                        else if (iv == '0)
                        begin
                            res_next.kind        = KIND_AVERAGE;
                            res_next.avg_freq_q8 = AVG_MAX;
                            state_next           = S_DONE;
                        end
                        else
                        begin
                            res_next.kind = KIND_AVERAGE;
                            mcnt_next     = cnt_upd - 1'b1;
                            addend_next   = NUM_W'(FS_PER_S) << FRACTION_BITS;
                            acc_next      = NUM_W'(iv);
                            dvsr_next     = {iv, 1'b0};
                            state_next    = S_MUL;
                        end
                    end
                end
            end
            S_MUL:
            begin
                if (mcnt_reg == '0)
                    state_next = S_DIV_GO;
                else
                begin
                    if (mcnt_reg[0])
                        acc_next = acc_reg + addend_reg;
                    addend_next = addend_reg << 1;
                    mcnt_next   = mcnt_reg >> 1;
                end
            end
            S_DIV_GO:
            begin
                div_req.start     = 1'b1;
                div_req.short_num = (res_reg.kind == KIND_PERIOD);
                state_next        = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    if (res_reg.kind == KIND_PERIOD)
                        res_next.freq_hz = div_q[FREQ_W-1:0];
                    else
                        res_next.avg_freq_q8 = div_stat.over ? AVG_MAX : div_q;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ovalid_reg || results.ready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = res_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            first_reg  <= '0;
            anchor_reg <= '0;
            last_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            first_reg  <= first_next;
            anchor_reg <= anchor_next;
            last_reg   <= last_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcnt_reg   <= mcnt_next;
        addend_reg <= addend_next;
        acc_reg    <= acc_next;
        dvsr_reg   <= dvsr_next;
        res_reg    <= res_next;
        odata_reg  <= odata_next;
    end

    epfm_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .numerator (acc_reg),
        .divisor   (dvsr_reg),
        .stat      (div_stat),
        .quotient  (div_q)
    );

    assign edges.ready   = (state_reg == S_IDLE);
    assign results.valid = ovalid_reg;
    assign results.data  = odata_reg;

    `EPFM_ASSERT_NOW(a_div_done_in_wait, div_stat.done, state_reg == S_DIV,
        "divider finished outside the wait state")
    `EPFM_ASSERT_NEXT(a_capture_cleared,
        edges.valid && edges.ready && edges.data.end_of_capture,
        count_reg == '0 && first_reg == '0 && last_reg == '0,
        "capture state not cleared after end of capture")
    `EPFM_ASSERT_NOW(a_divisor_nonzero, state_reg == S_DIV_GO || state_reg == S_MUL,
        dvsr_reg != '0, "division started with a zero divisor")
    `EPFM_ASSERT_NOW(a_period_no_count,
        results.valid && results.data.kind == KIND_PERIOD,
        results.data.edges_seen == '0 && results.data.avg_freq_q8 == '0,
        "period result carries capture fields")

endmodule
